// ===== rtl/abs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pkg
// Shared types, constants and register codes of the adaptive background
// subtraction block.
// ----------------------------------------------------------------------------
package abs_pkg;

  localparam int unsigned IDX_W   = 18;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned MASK_W  = 17;
  localparam int unsigned MEAN_W  = 18;
  localparam int unsigned THR_W   = 9;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned MAIN_W  = 3 * MEAN_W + MASK_W;
  localparam int unsigned HIST_W  = 3 * CH_W;

  localparam int unsigned FRAME_PIXELS_DEF   = 262144;
  localparam int unsigned HISTORY_FRAMES_DEF = 10;

  localparam logic [MASK_W-1:0] MASK_ONE   = 17'd65536;
  localparam logic [THR_W-1:0]  THR_RESET  = 9'd225;
  localparam logic [MASK_W-1:0] RAISE_RESET = 17'd3277;
  localparam logic [MASK_W-1:0] DROP_RESET  = 17'd13107;
  localparam int                MEAN_MIN   = -32768;
  localparam int                MEAN_MAX   = 131071;
  localparam int                OFFSET_Q8  = 127 * 256;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_LEARN     = 2'd1,
    CFG_RAISE     = 2'd2,
    CFG_DROP      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic              learn;
    logic [MASK_W-1:0] raise_step;
    logic [MASK_W-1:0] drop_step;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/abs_pix_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pix_if
// Input pixel channel: one beat carries one YUV pixel and its index.
// ----------------------------------------------------------------------------
interface abs_pix_if;
  logic        valid;
  logic        ready;
  logic [17:0] pixel_index;
  logic [7:0]  luma;
  logic [7:0]  chroma_blue;
  logic [7:0]  chroma_red;
  logic        frame_end;

  modport source (output valid, pixel_index, luma, chroma_blue, chroma_red, frame_end,
                  input ready);
  modport sink (input valid, pixel_index, luma, chroma_blue, chroma_red, frame_end,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/abs_res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_res_if
// Result channel: one beat carries the motion flag, mask and luma mean.
// ----------------------------------------------------------------------------
interface abs_res_if;
  logic               valid;
  logic               ready;
  logic               motion;
  logic [16:0]        mask_level;
  logic signed [17:0] background_luma;

  modport source (output valid, motion, mask_level, background_luma, input ready);
  modport sink (input valid, motion, mask_level, background_luma, output ready);
endinterface
`default_nettype wire

// ===== rtl/adaptive_background_subtract.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_background_subtract
// Per-pixel running-average background subtraction with an adaptive mask.
// ----------------------------------------------------------------------------
// Each beat is registered in abs_index and in each abs_pipe stage.
// Throughput: one pixel per cycle while res_out is ready; a pixel whose index
// matches one of three items in the pipeline waits until that item's write.
// Reset: after rst_ni rises, a clearing pass writes every pixel address,
// zeroing all means and setting all masks to 1.0; no pixel enters the pipe.
module adaptive_background_subtract
  import abs_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS   = FRAME_PIXELS_DEF,
  parameter int unsigned HISTORY_FRAMES = HISTORY_FRAMES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  abs_pix_if.sink               pix_in,
  abs_res_if.source             res_out
);

  localparam int unsigned PW  = $clog2(FRAME_PIXELS);
  localparam int unsigned HAW = $clog2(FRAME_PIXELS * HISTORY_FRAMES);

  cfg_t cfg_q;
  logic [PW:0] clr_q;
  logic        clearing;

  logic              req_valid, req_ready;
  logic [PW-1:0]     req_pix;
  logic [HAW-1:0]    req_haddr;
  logic [HIST_W-1:0] req_sample;

  logic              main_re, main_we, p_main_we;
  logic [PW-1:0]     main_raddr, main_waddr, p_main_waddr;
  logic [MAIN_W-1:0] main_rdata, main_wdata, p_main_wdata;
  logic              hist_re, hist_we;
  logic [HAW-1:0]    hist_raddr, hist_waddr;
  logic [HIST_W-1:0] hist_rdata, hist_wdata;

  assign clearing = (clr_q != (PW+1)'(FRAME_PIXELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q           <= '0;
      cfg_q.threshold <= THR_RESET;
      cfg_q.learn     <= 1'b1;
      cfg_q.raise_step <= RAISE_RESET;
      cfg_q.drop_step <= DROP_RESET;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + (PW+1)'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_THRESHOLD: cfg_q.threshold  <= cfg_data_i[THR_W-1:0];
          CFG_LEARN:     cfg_q.learn      <= cfg_data_i[0];
          CFG_RAISE:     cfg_q.raise_step <= cfg_data_i;
          CFG_DROP:      cfg_q.drop_step  <= cfg_data_i;
          default:       cfg_q.threshold  <= cfg_q.threshold;
        endcase
      end
    end
  end

  assign main_we    = clearing || p_main_we;
  assign main_waddr = clearing ? clr_q[PW-1:0] : p_main_waddr;
  assign main_wdata = clearing ? {MASK_ONE, {(3*MEAN_W){1'b0}}} : p_main_wdata;

  abs_index #(
    .FRAME_PIXELS  (FRAME_PIXELS),
    .HISTORY_FRAMES(HISTORY_FRAMES)
  ) u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_in       (pix_in),
    .req_valid_o  (req_valid),
    .req_ready_i  (req_ready),
    .req_pix_o    (req_pix),
    .req_haddr_o  (req_haddr),
    .req_sample_o (req_sample)
  );

  abs_pipe #(
    .FRAME_PIXELS  (FRAME_PIXELS),
    .HISTORY_FRAMES(HISTORY_FRAMES)
  ) u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (clearing),
    .cfg_i        (cfg_q),
    .req_valid_i  (req_valid),
    .req_ready_o  (req_ready),
    .req_pix_i    (req_pix),
    .req_haddr_i  (req_haddr),
    .req_sample_i (req_sample),
    .main_re_o    (main_re),
    .main_raddr_o (main_raddr),
    .main_rdata_i (main_rdata),
    .main_we_o    (p_main_we),
    .main_waddr_o (p_main_waddr),
    .main_wdata_o (p_main_wdata),
    .hist_re_o    (hist_re),
    .hist_raddr_o (hist_raddr),
    .hist_rdata_i (hist_rdata),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata),
    .res_valid_o  (res_out.valid),
    .res_ready_i  (res_out.ready),
    .motion_o     (res_out.motion),
    .mask_o       (res_out.mask_level),
    .bg_o         (res_out.background_luma)
  );

  abs_ram #(
    .WIDTH(MAIN_W),
    .DEPTH(FRAME_PIXELS)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .re_i    (main_re),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  abs_ram #(
    .WIDTH(HIST_W),
    .DEPTH(FRAME_PIXELS * HISTORY_FRAMES)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

endmodule
`default_nettype wire

// ===== rtl/abs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
module abs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/abs_index.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_index
// Input stage: registers the pixel beat, folds the index into the frame and
// forms the history address from the current ring slot.
// ----------------------------------------------------------------------------
module abs_index
  import abs_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS   = FRAME_PIXELS_DEF,
  parameter int unsigned HISTORY_FRAMES = HISTORY_FRAMES_DEF,
  localparam int unsigned PW  = $clog2(FRAME_PIXELS),
  localparam int unsigned HAW = $clog2(FRAME_PIXELS * HISTORY_FRAMES)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  abs_pix_if.sink                    pix_in,
  output logic                       req_valid_o,
  input  wire logic                  req_ready_i,
  output logic [PW-1:0]              req_pix_o,
  output logic [HAW-1:0]             req_haddr_o,
  output logic [HIST_W-1:0]          req_sample_o
);

  localparam int unsigned SP  = 20;
  localparam int unsigned RP  = (1 << SP) / FRAME_PIXELS;
  localparam int unsigned MW  = IDX_W + 24;
  localparam int unsigned SW  = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;

  logic              va_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  quo_q;
  logic [HIST_W-1:0] smp_q;
  logic              fe_q;
  logic [SW-1:0]     slot_q;
  logic [HAW-1:0]    hbase_q;

  logic [IDX_W+SP:0] quo_prod;
  logic [MW-1:0]     rem_raw;
  logic [MW-1:0]     rem;
  logic              fire;

  assign quo_prod = (IDX_W+SP+1)'(pix_in.pixel_index) * (IDX_W+SP+1)'(RP);
  assign rem_raw  = MW'(idx_q) - MW'(quo_q) * MW'(FRAME_PIXELS);
  assign rem      = (rem_raw >= MW'(FRAME_PIXELS)) ? rem_raw - MW'(FRAME_PIXELS) : rem_raw;

  assign fire         = va_q && req_ready_i;
  assign pix_in.ready = !va_q || req_ready_i;
  assign req_valid_o  = va_q;
  assign req_pix_o    = rem[PW-1:0];
  assign req_haddr_o  = hbase_q + HAW'(rem[PW-1:0]);
  assign req_sample_o = smp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      slot_q  <= '0;
      hbase_q <= '0;
    end else begin
      if (pix_in.ready) begin
        va_q <= pix_in.valid;
      end
      if (fire && fe_q) begin
        if (slot_q == SW'(HISTORY_FRAMES - 1)) begin
          slot_q  <= '0;
          hbase_q <= '0;
        end else begin
          slot_q  <= slot_q + SW'(1);
          hbase_q <= hbase_q + HAW'(FRAME_PIXELS);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_in.ready && pix_in.valid) begin
      idx_q <= pix_in.pixel_index;
      quo_q <= quo_prod[SP+IDX_W-1:SP];
      smp_q <= {pix_in.chroma_red, pix_in.chroma_blue, pix_in.luma};
      fe_q  <= pix_in.frame_end;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/abs_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// abs_pipe
// Read-modify-write pipeline: scales the differences by the mask, squares,
// decides motion, updates mask (detect mode only) and means and writes both memories back.
// ----------------------------------------------------------------------------
module abs_pipe
  import abs_pkg::*;
#(
  parameter int unsigned FRAME_PIXELS   = FRAME_PIXELS_DEF,
  parameter int unsigned HISTORY_FRAMES = HISTORY_FRAMES_DEF,
  localparam int unsigned PW  = $clog2(FRAME_PIXELS),
  localparam int unsigned HAW = $clog2(FRAME_PIXELS * HISTORY_FRAMES)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     clear_i,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     req_valid_i,
  output logic                          req_ready_o,
  input  wire logic [PW-1:0]            req_pix_i,
  input  wire logic [HAW-1:0]           req_haddr_i,
  input  wire logic [HIST_W-1:0]        req_sample_i,
  output logic                          main_re_o,
  output logic [PW-1:0]                 main_raddr_o,
  input  wire logic [MAIN_W-1:0]        main_rdata_i,
  output logic                          main_we_o,
  output logic [PW-1:0]                 main_waddr_o,
  output logic [MAIN_W-1:0]             main_wdata_o,
  output logic                          hist_re_o,
  output logic [HAW-1:0]                hist_raddr_o,
  input  wire logic [HIST_W-1:0]        hist_rdata_i,
  output logic                          hist_we_o,
  output logic [HAW-1:0]                hist_waddr_o,
  output logic [HIST_W-1:0]             hist_wdata_o,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output logic                          motion_o,
  output logic [MASK_W-1:0]             mask_o,
  output logic signed [MEAN_W-1:0]      bg_o
);

  localparam int unsigned RH   = ((1 << 24) + HISTORY_FRAMES - 1) / HISTORY_FRAMES;
  localparam int unsigned HALF = HISTORY_FRAMES / 2;

  logic v1_q, v2_q, v3_q, vo_q;
  logic adv2, adv3, advo, issue, hazard;

  logic [PW-1:0]     pix1_q, pix2_q, pix3_q;
  logic [HAW-1:0]    ha1_q, ha2_q, ha3_q;
  logic [HIST_W-1:0] smp1_q, smp2_q, smp3_q;
  logic [MASK_W-1:0] mask2_q, mask3_q;

  logic [2:0][16:0]        s1;
  logic [2:0][15:0]        shn1, sho1;
  logic [2:0][16:0]        s2_q;
  logic [2:0][15:0]        shn2_q, sho2_q;
  logic [2:0][MEAN_W-1:0]  bg2_q;
  logic [2:0][33:0]        sq2;
  logic [2:0][MEAN_W-1:0]  bgn2;
  logic [2:0][33:0]        sq3_q;
  logic [2:0][MEAN_W-1:0]  bgn3_q;

  logic [17:0]       thr_sq_q;
  logic [35:0]       sum3;
  logic              motion3;
  logic signed [18:0] nm_raw;
  logic [MASK_W-1:0] nm;

  logic              mo_q;
  logic [MASK_W-1:0] mask_q;
  logic [MEAN_W-1:0] bg_q;

  assign advo  = v3_q && (!vo_q || res_ready_i);
  assign adv3  = v2_q && (!v3_q || advo);
  assign adv2  = v1_q && (!v2_q || adv3);

  assign hazard = (v1_q && (pix1_q == req_pix_i)) || (v2_q && (pix2_q == req_pix_i)) ||
                  (v3_q && (pix3_q == req_pix_i));
  assign req_ready_o = !clear_i && (!v1_q || adv2) && !hazard;
  assign issue       = req_valid_i && req_ready_o;

  assign main_re_o    = issue;
  assign main_raddr_o = req_pix_i;
  assign hist_re_o    = issue;
  assign hist_raddr_o = req_haddr_i;

  for (genvar k = 0; k < 3; k++) begin : g_ch
    logic signed [19:0] d;
    logic [16:0]        mag;
    logic [33:0]        prod;
    logic [40:0]        pn, po;
    logic signed [19:0] t;
    logic signed [19:0] bgx;

    always_comb begin
      d    = $signed({4'b0, smp1_q[k*CH_W +: CH_W], 8'b0}) + 20'(OFFSET_Q8) -
             $signed({{2{main_rdata_i[k*MEAN_W+MEAN_W-1]}}, main_rdata_i[k*MEAN_W +: MEAN_W]});
      mag  = d[19] ? 17'(-d) : 17'(d);
      prod = 34'(mag) * 34'(main_rdata_i[MAIN_W-1 -: MASK_W]);
      s1[k] = prod[32:16];
      pn   = 41'({smp1_q[k*CH_W +: CH_W], 8'b0} + 16'(HALF)) * 41'(RH);
      po   = 41'({hist_rdata_i[k*CH_W +: CH_W], 8'b0} + 16'(HALF)) * 41'(RH);
      shn1[k] = pn[39:24];
      sho1[k] = po[39:24];
    end

    always_comb begin
      sq2[k] = 34'(s2_q[k]) * 34'(s2_q[k]);
      bgx    = {{2{bg2_q[k][MEAN_W-1]}}, bg2_q[k]};
      t      = bgx + $signed({4'b0, shn2_q[k]}) -
               (cfg_i.learn ? 20'sd0 : $signed({4'b0, sho2_q[k]}));
      if (t < 20'(MEAN_MIN)) begin
        bgn2[k] = MEAN_W'(MEAN_MIN);
      end else if (t > 20'(MEAN_MAX)) begin
        bgn2[k] = MEAN_W'(MEAN_MAX);
      end else begin
        bgn2[k] = t[MEAN_W-1:0];
      end
    end
  end

  always_comb begin
    sum3    = 36'(sq3_q[0]) + 36'(sq3_q[1]) + 36'(sq3_q[2]);
    motion3 = !cfg_i.learn && (sum3 >= 36'({thr_sq_q, 16'b0}));
    nm_raw  = $signed({2'b0, mask3_q}) +
              (motion3 ? -$signed({2'b0, cfg_i.drop_step}) : $signed({2'b0, cfg_i.raise_step}));
    if (nm_raw < 19'sd0) begin
      nm = '0;
    end else if (nm_raw > $signed({2'b0, MASK_ONE})) begin
      nm = MASK_ONE;
    end else begin
      nm = nm_raw[MASK_W-1:0];
    end
    if (cfg_i.learn) begin
      nm = mask3_q;
    end
  end

  assign main_we_o    = advo;
  assign main_waddr_o = pix3_q;
  assign main_wdata_o = {nm, bgn3_q[2], bgn3_q[1], bgn3_q[0]};
  assign hist_we_o    = advo;
  assign hist_waddr_o = ha3_q;
  assign hist_wdata_o = smp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      vo_q     <= 1'b0;
      thr_sq_q <= '0;
    end else begin
      v1_q     <= issue || (v1_q && !adv2);
      v2_q     <= adv2 || (v2_q && !adv3);
      v3_q     <= adv3 || (v3_q && !advo);
      vo_q     <= advo || (vo_q && !res_ready_i);
      thr_sq_q <= 18'(cfg_i.threshold) * 18'(cfg_i.threshold);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pix1_q <= req_pix_i;
      ha1_q  <= req_haddr_i;
      smp1_q <= req_sample_i;
    end
    if (adv2) begin
      pix2_q  <= pix1_q;
      ha2_q   <= ha1_q;
      smp2_q  <= smp1_q;
      mask2_q <= main_rdata_i[MAIN_W-1 -: MASK_W];
      s2_q    <= s1;
      shn2_q  <= shn1;
      sho2_q  <= sho1;
      for (int k = 0; k < 3; k++) begin
        bg2_q[k] <= main_rdata_i[k*MEAN_W +: MEAN_W];
      end
    end
    if (adv3) begin
      pix3_q  <= pix2_q;
      ha3_q   <= ha2_q;
      smp3_q  <= smp2_q;
      mask3_q <= mask2_q;
      sq3_q   <= sq2;
      bgn3_q  <= bgn2;
    end
    if (advo) begin
      mo_q   <= motion3;
      mask_q <= nm;
      bg_q   <= bgn3_q[0];
    end
  end

  assign res_valid_o = vo_q;
  assign motion_o    = mo_q;
  assign mask_o      = mask_q;
  assign bg_o        = $signed(bg_q);

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks adaptive_background_subtract against a behavioral predictor of the
// per-pixel background mean, history ring and adaptive mask. A directed table
// covers reset values, learn-mode bootstrap, mean saturation and the mask
// extremes, then random pixel streams run under changing register settings
// and three idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import abs_pkg::*;

  localparam int NPIX  = FRAME_PIXELS_DEF;
  localparam int NHIST = HISTORY_FRAMES_DEF;
  localparam int POOL_N = 12;
  localparam int IDLE_LIMIT = 1000000;

  typedef enum logic [1:0] {ROW_PIX, ROW_CFG, ROW_BOOT} row_kind_e;
  typedef enum logic [1:0] {EXP_NONE, EXP_MASK, EXP_FULL} row_exp_e;

  typedef struct packed {
    logic               motion;
    logic [MASK_W-1:0]  mask_level;
    logic signed [17:0] background_luma;
  } result_t;

  typedef struct {
    row_kind_e         kind;
    cfg_idx_e          idx;
    logic [CFG_W-1:0]  data;
    logic [IDX_W-1:0]  pix;
    logic [7:0]        y, u, v;
    logic              fe;
    row_exp_e          exp_kind;
    result_t           exp_res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  abs_pix_if pix_bus ();
  abs_res_if res_bus ();

  adaptive_background_subtract DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_in     (pix_bus),
    .res_out    (res_bus)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor state.
  int          mean_y[int], mean_u[int], mean_v[int];
  int          mask_mem[int];
  logic [23:0] hist_mem[int];
  int          slot_now = 0;
  int          thr_reg = int'(THR_RESET);
  bit          learn_reg = 1'b1;
  int          raise_reg = int'(RAISE_RESET);
  int          drop_reg = int'(DROP_RESET);

  result_t     pending_results[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          motion_seen = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          recv_hold = 0;
  logic [IDX_W-1:0] pool [POOL_N];

  function automatic int share(input int x);
    return (x * 256 + NHIST / 2) / NHIST;
  endfunction

  function automatic int clamp_mean(input int x);
    if (x < MEAN_MIN) return MEAN_MIN;
    if (x > MEAN_MAX) return MEAN_MAX;
    return x;
  endfunction

  function automatic result_t predict_pixel(input logic [IDX_W-1:0] pix,
                                            input logic [7:0] y, u, v,
                                            input logic fe);
    int      p, hidx, mask, nm, old_y, old_u, old_v, my, mu, mv;
    longint  mag, sc, sumsq, limit;
    int      smp [3];
    int      mn [3];
    result_t r;
    p = int'(pix) % NPIX;
    hidx = slot_now * NPIX + p;
    my = mean_y.exists(p) ? mean_y[p] : 0;
    mu = mean_u.exists(p) ? mean_u[p] : 0;
    mv = mean_v.exists(p) ? mean_v[p] : 0;
    mask = mask_mem.exists(p) ? mask_mem[p] : int'(MASK_ONE);
    smp[0] = int'(y); smp[1] = int'(u); smp[2] = int'(v);
    mn[0] = my; mn[1] = mu; mn[2] = mv;
    r.motion = 1'b0;
    if (learn_reg) begin
      my = clamp_mean(my + share(int'(y)));
      mu = clamp_mean(mu + share(int'(u)));
      mv = clamp_mean(mv + share(int'(v)));
    end else begin
      sumsq = 0;
      limit = longint'(thr_reg) * thr_reg * 65536;
      for (int k = 0; k < 3; k++) begin
        mag = longint'(smp[k]) * 256 + OFFSET_Q8 - mn[k];
        if (mag < 0) mag = -mag;
        sc = (mag * mask) >>> 16;
        sumsq += sc * sc;
      end
      r.motion = (sumsq >= limit);
      nm = mask + (r.motion ? -drop_reg : raise_reg);
      if (nm < 0) nm = 0;
      if (nm > int'(MASK_ONE)) nm = int'(MASK_ONE);
      mask = nm;
      mask_mem[p] = mask;
      old_y = hist_mem.exists(hidx) ? int'(hist_mem[hidx][23:16]) : 0;
      old_u = hist_mem.exists(hidx) ? int'(hist_mem[hidx][15:8]) : 0;
      old_v = hist_mem.exists(hidx) ? int'(hist_mem[hidx][7:0]) : 0;
      my = clamp_mean(my + share(int'(y)) - share(old_y));
      mu = clamp_mean(mu + share(int'(u)) - share(old_u));
      mv = clamp_mean(mv + share(int'(v)) - share(old_v));
    end
    mean_y[p] = my; mean_u[p] = mu; mean_v[p] = mv;
    hist_mem[hidx] = {y, u, v};
    if (fe) slot_now = (slot_now + 1) % NHIST;
    r.mask_level = mask[MASK_W-1:0];
    r.background_luma = my[17:0];
    return r;
  endfunction

  task automatic send_pixel(input logic [IDX_W-1:0] pix, input logic [7:0] y, u, v,
                            input logic fe, input row_exp_e ek, input result_t er);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk_i);
    end
    pix_bus.valid = 1'b1;
    pix_bus.pixel_index = pix;
    pix_bus.luma = y;
    pix_bus.chroma_blue = u;
    pix_bus.chroma_red = v;
    pix_bus.frame_end = fe;
    do @(posedge clk_i); while (!pix_bus.ready);
    r = predict_pixel(pix, y, u, v, fe);
    if (ek == EXP_FULL) r = er;
    else if (ek == EXP_MASK) begin
      r.motion = er.motion;
      r.mask_level = er.mask_level;
    end
    pending_results.push_back(r);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg = val & 9'h1FF;
      CFG_LEARN:     learn_reg = val[0];
      CFG_RAISE:     raise_reg = val & 17'h1FFFF;
      CFG_DROP:      drop_reg = val & 17'h1FFFF;
      default: ;
    endcase
  endtask

  // Every pool pixel gets written in all history slots, so detect mode may use it
  // from any slot. Pixel 5 is then pushed into mean saturation.
  task automatic bootstrap();
    for (int f = 0; f < NHIST; f++) begin
      for (int i = 0; i < POOL_N; i++) begin
        send_pixel(pool[i], 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), i == POOL_N - 1, EXP_NONE, '0);
      end
    end
    for (int i = 0; i < 24; i++) send_pixel(18'd5, 8'd255, 8'd255, 8'd255, 1'b0, EXP_NONE, '0);
  endtask

  function automatic logic [IDX_W-1:0] pick_pixel();
    logic [IDX_W-1:0] p;
    p = IDX_W'($urandom_range(NPIX - 1));
    if ($urandom_range(3) == 0 && (learn_reg || hist_mem.exists(slot_now * NPIX + int'(p))))
      return p;
    return pool[$urandom_range(POOL_N - 1)];
  endfunction

  function automatic int pick_step();
    case ($urandom_range(3))
      0: return 0;
      1: return 65536;
      default: return $urandom_range(65536);
    endcase
  endfunction

  row_t dir_rows [$];

  function automatic row_t mk_pix(input int pix, input int y, u, v, input bit fe,
                                  input row_exp_e ek, input result_t er);
    row_t r;
    r.kind = ROW_PIX; r.idx = CFG_THRESHOLD; r.data = '0;
    r.pix = IDX_W'(pix); r.y = 8'(y); r.u = 8'(u); r.v = 8'(v); r.fe = fe;
    r.exp_kind = ek; r.exp_res = er;
    return r;
  endfunction

  function automatic row_t mk_cfg(input cfg_idx_e idx, input int val);
    row_t r;
    r = mk_pix(0, 0, 0, 0, 1'b0, EXP_NONE, '0);
    r.kind = ROW_CFG; r.idx = idx; r.data = CFG_W'(val);
    return r;
  endfunction

  initial begin
    row_t  rw;
    result_t none;
    none = '0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_index = '0;
    pix_bus.luma = '0;
    pix_bus.chroma_blue = '0;
    pix_bus.chroma_red = '0;
    pix_bus.frame_end = 1'b0;
    pool = '{18'd0, 18'd1, 18'd2, 18'd3, 18'd4, 18'd5, 18'd6, 18'd7,
             18'd131072, 18'h15555, 18'h2AAAA, 18'h3FFFF};

    dir_rows.push_back(mk_pix(0, 255, 255, 255, 0, EXP_FULL, '{1'b0, MASK_ONE, 18'sd6528}));
    dir_rows.push_back(mk_pix(262143, 0, 255, 0, 1, EXP_FULL, '{1'b0, MASK_ONE, 18'sd0}));
    dir_rows.push_back(mk_pix(0, 255, 0, 0, 0, EXP_FULL, '{1'b0, MASK_ONE, 18'sd13056}));
    dir_rows.push_back(mk_pix(18'h15555, 170, 85, 170, 0, EXP_NONE, none));
    dir_rows.push_back(mk_pix(18'h2AAAA, 85, 170, 85, 1, EXP_NONE, none));
    rw = mk_pix(0, 0, 0, 0, 0, EXP_NONE, none);
    rw.kind = ROW_BOOT;
    dir_rows.push_back(rw);
    dir_rows.push_back(mk_cfg(CFG_LEARN, 0));
    dir_rows.push_back(mk_pix(1, 127, 127, 127, 0, EXP_NONE, none));
    dir_rows.push_back(mk_pix(5, 0, 0, 0, 0, EXP_NONE, none));
    dir_rows.push_back(mk_cfg(CFG_THRESHOLD, 0));
    dir_rows.push_back(mk_cfg(CFG_DROP, 65536));
    dir_rows.push_back(mk_pix(2, 0, 255, 0, 0, EXP_MASK, '{1'b1, 17'd0, 18'sd0}));
    dir_rows.push_back(mk_cfg(CFG_RAISE, 65536));
    dir_rows.push_back(mk_cfg(CFG_THRESHOLD, 511));
    dir_rows.push_back(mk_pix(2, 255, 0, 255, 0, EXP_MASK, '{1'b0, MASK_ONE, 18'sd0}));
    dir_rows.push_back(mk_cfg(CFG_THRESHOLD, 225));
    dir_rows.push_back(mk_cfg(CFG_RAISE, 3277));
    dir_rows.push_back(mk_cfg(CFG_DROP, 13107));
    dir_rows.push_back(mk_pix(262143, 255, 255, 255, 1, EXP_NONE, none));
    dir_rows.push_back(mk_pix(3, 128, 128, 128, 0, EXP_NONE, none));
    dir_rows.push_back(mk_pix(3, 200, 10, 60, 0, EXP_NONE, none));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      case (rw.kind)
        ROW_CFG: begin
          drain();
          write_reg(rw.idx, int'(rw.data));
        end
        ROW_BOOT: bootstrap();
        default: send_pixel(rw.pix, rw.y, rw.u, rw.v, rw.fe, rw.exp_kind, rw.exp_res);
      endcase
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 51 : 0;
      recv_idle_pct = (ph == 0) ? 51 : (ph == 1) ? 27 : 0;
      for (int blk = 0; blk < 5; blk++) begin
        drain();
        case ($urandom_range(3))
          0: write_reg(CFG_THRESHOLD, 0);
          1: write_reg(CFG_THRESHOLD, 511);
          default: write_reg(CFG_THRESHOLD, $urandom_range(511));
        endcase
        write_reg(CFG_RAISE, pick_step());
        write_reg(CFG_DROP, pick_step());
        write_reg(CFG_LEARN, int'($urandom_range(4) == 0));
        if (ph == 2 && blk == 0) recv_hold = 300;
        for (int n = 0; n < 135; n++) begin
          send_pixel(pick_pixel(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), $urandom_range(15) == 0, EXP_NONE, '0);
        end
      end
    end

    drain();
    $display("Sent %0d pixels, checked %0d results, %0d flagged as motion.",
             items_sent, results_seen, motion_seen);
    $display("Covered learn and detect modes, mask and threshold extremes, mean saturation.");
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_hold > 0) begin
        res_bus.ready = 1'b0;
        recv_hold--;
      end else begin
        res_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (res_bus.motion) motion_seen++;
      if (pending_results.size() == 0) begin
        $error("Result beat with no pixel outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (res_bus.motion !== e.motion) begin
          $error("motion: expected %0d, got %0d", e.motion, res_bus.motion);
          fail_count++;
        end
        if (res_bus.mask_level !== e.mask_level) begin
          $error("mask_level: expected %0d, got %0d", e.mask_level, res_bus.mask_level);
          fail_count++;
        end
        if (res_bus.background_luma !== e.background_luma) begin
          $error("background_luma: expected %0d, got %0d", e.background_luma,
                 res_bus.background_luma);
          fail_count++;
        end
      end
    end
    if ((res_bus.valid && res_bus.ready) || (pix_bus.valid && pix_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
